@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RC4 keystream cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rc4ks_pkg.sv @@
// Package: shared types and constants of the RC4 keystream cipher.
`timescale 1ns / 1ps
package rc4ks_pkg;

    localparam int BYTE_W     = 8;
    localparam int KEY_WORDS  = 4;
    localparam int KEY_WORD_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 6;
    localparam int SKIP_W     = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KEYLEN = 3'd4,
        REG_SKIP   = 3'd5
    } cfg_reg_t;

    // top -> core control
    typedef struct packed {
        logic start;     // input beat accepted
        logic restart;   // first byte of a message
        logic out_free;  // output register can take a result
    } rc4ks_cmd_t;

    // core -> top status
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] ks_byte;
    } rc4ks_rsp_t;

endpackage

@@ rtl/rc4_keystream_cipher_unit.sv @@
// Top level: RC4 stream cipher with keystream skip, config registers and output register.
// Each input beat returns one output beat: data_byte XOR the next RC4 keystream byte.
// Encryption and decryption are the same operation. When first is set, or on the first
// beat after reset, the block rebuilds the 256-entry permutation: an identity fill of
// every entry, a key schedule of two reads and two swap writes per entry, then the same
// reads and writes for each of the skip_count discarded keystream bytes. A normal beat
// goes from accept through the permutation reads and swap writes, hands the result to
// the output register once that register can take it, then returns to idle to take the
// next beat. These steps are set by the permutation memory, which has one write port and
// one registered read port: each read address depends on the data of the read before it.
// The input side is stalled while a beat is in flight; a result waits
// in the output register until taken. Key length 0 acts as 1 and lengths above
// MAX_KEY_BYTES saturate. Configuration takes effect at the next restart and must be
// written while the block is idle; writes to unknown indexes are dropped.
`timescale 1ns / 1ps
module rc4_keystream_cipher_unit
    import rc4ks_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [KEY_WORD_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  first,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     result_byte
);

    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [KEY_WORD_W-1:0]             key_word_reg [KEY_WORDS];
    logic [LEN_W-1:0]                  key_length_reg;
    logic [SKIP_W-1:0]                 skip_count_reg;
    logic [KEY_WORDS*KEY_WORD_W-1:0]   key_all;
    logic [LEN_W-1:0]                  len_eff;

    logic [BYTE_W-1:0]                 data_reg;
    logic                              out_valid_reg;
    logic [BYTE_W-1:0]                 result_reg;

    rc4ks_cmd_t                        cmd;
    rc4ks_rsp_t                        rsp;

    // Config registers; always ready, one beat per cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_WORDS; k++)
            begin
                key_word_reg[k] <= '0;
            end
            key_length_reg <= LEN_W'(16);
            skip_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY0:   key_word_reg[0] <= cfg_data;
                REG_KEY1:   key_word_reg[1] <= cfg_data;
                REG_KEY2:   key_word_reg[2] <= cfg_data;
                REG_KEY3:   key_word_reg[3] <= cfg_data;
                REG_KEYLEN: key_length_reg  <= cfg_data[LEN_W-1:0];
                REG_SKIP:   skip_count_reg  <= cfg_data[SKIP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Key byte n sits at byte n mod 8 of word n/8, so the words simply concatenate.
    assign key_all = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]};

    // Effective key length: zero acts as one, clamp at MAX_KEY_BYTES.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (key_length_reg > LEN_W'(MAX_KEY_BYTES))
        begin
            len_eff = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            len_eff = key_length_reg;
        end
    end

    // Input side: one beat in flight at a time.
    assign in_stall    = rsp.busy;
    assign cmd.start   = in_valid && !in_stall;
    assign cmd.restart = first;
    assign cmd.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            data_reg <= data_byte;
        end
    end

    rc4ks_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .KPOS_W        (KPOS_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key_all[MAX_KEY_BYTES*BYTE_W-1:0]),
        .key_len    (len_eff),
        .skip_count (skip_count_reg),
        .rsp        (rsp)
    );

    // Output register: loaded when the core hands over a keystream byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.done)
        begin
            result_reg <= data_reg ^ rsp.ks_byte;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

endmodule

@@ rtl/rc4ks_core.sv @@
// Core: permutation memory plus sequencer for key schedule, skip and keystream.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rc4ks_core
    import rc4ks_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32,
    parameter int KPOS_W        = 5
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rc4ks_cmd_t                      cmd,
    input  logic [MAX_KEY_BYTES*BYTE_W-1:0] key,
    input  logic [LEN_W-1:0]                key_len,
    input  logic [SKIP_W-1:0]               skip_count,
    output rc4ks_rsp_t                      rsp
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_FILL  = 11'b000_0000_0010,
        ST_KS_RN = 11'b000_0000_0100,
        ST_KS_RJ = 11'b000_0000_1000,
        ST_KS_W1 = 11'b000_0001_0000,
        ST_KS_W2 = 11'b000_0010_0000,
        ST_RI    = 11'b000_0100_0000,
        ST_RJ    = 11'b000_1000_0000,
        ST_W1    = 11'b001_0000_0000,
        ST_W2    = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [BYTE_W-1:0]   n_reg, n_next;
    logic [BYTE_W-1:0]   i_reg, i_next;
    logic [BYTE_W-1:0]   j_reg, j_next;
    logic [KPOS_W-1:0]   kpos_reg, kpos_next;
    logic [SKIP_W-1:0]   skip_left_reg, skip_left_next;
    logic                keyed_reg, keyed_next;
    logic [BYTE_W-1:0]   si_reg, si_next;
    logic [BYTE_W-1:0]   sj_reg, sj_next;
    logic                byp_reg, byp_next;

    logic [BYTE_W-1:0]   sbox_mem [256];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                mem_we, mem_re;
    logic [BYTE_W-1:0]   mem_waddr, mem_wdata, mem_raddr;

    logic [BYTE_W-1:0]   key_bytes [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]   key_byte;
    logic [BYTE_W-1:0]   j_sum;
    logic [BYTE_W-1:0]   t_addr;
    logic [KPOS_W:0]     kpos_inc;
    logic                kpos_wrap;
    logic                done;

    always_comb
    begin
        for (int k = 0; k < MAX_KEY_BYTES; k++)
        begin
            key_bytes[k] = key[k*BYTE_W +: BYTE_W];
        end
    end

    assign key_byte  = key_bytes[kpos_reg];
    assign t_addr    = BYTE_W'(si_reg + sj_reg);
    assign kpos_inc  = {1'b0, kpos_reg} + (KPOS_W+1)'(1);
    assign kpos_wrap = (LEN_W'(kpos_inc) >= key_len);

    // permutation memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sbox_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= sbox_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kpos_next      = kpos_reg;
        skip_left_next = skip_left_reg;
        keyed_next     = keyed_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        byp_next       = byp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        j_sum          = '0;
        done           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.restart || !keyed_reg)
                    begin
                        state_next = ST_FILL;
                        n_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_RI;
                    end
                end
            end
            ST_FILL:
            begin
                // identity permutation, one entry a cycle
                mem_we    = 1'b1;
                mem_waddr = n_reg;
                mem_wdata = n_reg;
                n_next    = BYTE_W'(n_reg + 8'd1);
                if (n_reg == 8'hff)
                begin
                    state_next     = ST_KS_RN;
                    j_next         = '0;
                    kpos_next      = '0;
                    skip_left_next = skip_count;
                end
            end
            ST_KS_RN:
            begin
                mem_re     = 1'b1;
                mem_raddr  = n_reg;
                state_next = ST_KS_RJ;
            end
            ST_KS_RJ:
            begin
                si_next    = rd_data_reg;
                j_sum      = BYTE_W'(j_reg + rd_data_reg + key_byte);
                j_next     = j_sum;
                mem_re     = 1'b1;
                mem_raddr  = j_sum;
                state_next = ST_KS_W1;
            end
            ST_KS_W1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = n_reg;
                mem_wdata  = rd_data_reg;
                state_next = ST_KS_W2;
            end
            ST_KS_W2:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                n_next    = BYTE_W'(n_reg + 8'd1);
                kpos_next = kpos_wrap ? '0 : KPOS_W'(kpos_inc);
                if (n_reg == 8'hff)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_RI;
                end
                else
                begin
                    state_next = ST_KS_RN;
                end
            end
            ST_RI:
            begin
                i_next     = BYTE_W'(i_reg + 8'd1);
                mem_re     = 1'b1;
                mem_raddr  = BYTE_W'(i_reg + 8'd1);
                state_next = ST_RJ;
            end
            ST_RJ:
            begin
                si_next    = rd_data_reg;
                j_sum      = BYTE_W'(j_reg + rd_data_reg);
                j_next     = j_sum;
                mem_re     = 1'b1;
                mem_raddr  = j_sum;
                state_next = ST_W1;
            end
            ST_W1:
            begin
                sj_next    = rd_data_reg;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = rd_data_reg;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                // second swap write; read S[t] alongside, bypass if t hits j
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                mem_re    = 1'b1;
                mem_raddr = t_addr;
                byp_next  = (t_addr == j_reg);
                if (skip_left_reg != '0)
                begin
                    skip_left_next = SKIP_W'(skip_left_reg - 16'd1);
                    state_next     = ST_RI;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (cmd.out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            kpos_reg      <= '0;
            skip_left_reg <= '0;
            keyed_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            kpos_reg      <= kpos_next;
            skip_left_reg <= skip_left_next;
            keyed_reg     <= keyed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        sj_reg  <= sj_next;
        byp_reg <= byp_next;
    end

    assign rsp.busy    = (state_reg != ST_IDLE);
    assign rsp.done    = done;
    assign rsp.ks_byte = byp_reg ? si_reg : rd_data_reg;

    `ASSERT_IMPLY(a_out_keyed, clk, rst_n, state_reg == ST_OUT, keyed_reg && (skip_left_reg == '0), "result before schedule and skip finished")
    `ASSERT_NEXT(a_fill_to_ks, clk, rst_n, (state_reg == ST_FILL) && (n_reg == 8'hff), state_reg == ST_KS_RN, "fill did not hand over to key schedule")
    `ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, cmd.start && (state_reg == ST_IDLE), (state_reg == ST_FILL) || (state_reg == ST_RI), "accepted beat not started")
    `ASSERT_IMPLY(a_kpos_range, clk, rst_n, state_reg == ST_KS_RJ, LEN_W'(kpos_reg) < key_len, "key position past key length")

endmodule
